[sv/dpv_sp_pkg.sv]
// ---------------------------------------------------------------------------
// dpv_sp_pkg
// Shared types and constants for the staircase pulse DAC word generator.
// ---------------------------------------------------------------------------
package dpv_sp_pkg;

	localparam int unsigned MaxSteps = 4096;
	localparam int unsigned FracBits = 8;
	localparam int unsigned CountW   = 13;
	localparam int unsigned StepW    = 16;
	localparam int unsigned StartW   = 21;
	localparam int unsigned PulseW   = 19;
	localparam int unsigned VzW      = 7;
	localparam int unsigned VzCodeW  = 6;
	localparam int unsigned VbiasW   = 12;
	localparam int unsigned BaseW    = 30;
	localparam int unsigned LevelW   = 31;
	localparam int unsigned DacW     = VzCodeW + VbiasW;
	localparam int unsigned CfgIdxW  = 3;
	localparam int unsigned CfgDataW = 21;

	localparam logic [VbiasW-1:0]  VbiasMax = VbiasW'(4095);
	localparam logic [VzCodeW-1:0] VzMax    = VzCodeW'(63);

	// configuration register indexes
	localparam logic [CfgIdxW-1:0] CFG_START_CODE   = 3'd0;
	localparam logic [CfgIdxW-1:0] CFG_STEP_CODE    = 3'd1;
	localparam logic [CfgIdxW-1:0] CFG_PULSE_CODE   = 3'd2;
	localparam logic [CfgIdxW-1:0] CFG_VZERO_START  = 3'd3;
	localparam logic [CfgIdxW-1:0] CFG_VZERO_PEAK   = 3'd4;
	localparam logic [CfgIdxW-1:0] CFG_STEP_COUNT   = 3'd5;

	typedef enum logic [1:0] {
		PH_INIT,
		PH_FIRST,
		PH_SECOND,
		PH_STOP
	} ramp_phase_t;

	typedef struct packed {
		logic signed [StartW-1:0] start_code;
		logic [StepW-1:0]         step_code;
		logic signed [PulseW-1:0] pulse_code;
		logic [VzW-1:0]           vzero_start_code;
		logic [VzW-1:0]           vzero_peak_code;
		logic [CountW-1:0]        step_count;
	} cfg_t;

endpackage

[sv/dpv_sp_if.sv]
// ---------------------------------------------------------------------------
// dpv_sp_if
// Valid/ready channels for request items and DAC word items.
// ---------------------------------------------------------------------------
interface dpv_sp_in_if;
	logic valid;
	logic ready;
	logic pulse_phase;

	modport source (output valid, output pulse_phase, input ready);
	modport sink (input valid, input pulse_phase, output ready);
endinterface

interface dpv_sp_out_if;
	logic        valid;
	logic        ready;
	logic [17:0] dac_word;
	logic [5:0]  vzero_code;
	logic [11:0] vbias_code;
	logic [12:0] step_index;

	modport source (output valid, output dac_word, output vzero_code, output vbias_code,
		output step_index, input ready);
	modport sink (input valid, input dac_word, input vzero_code, input vbias_code,
		input step_index, output ready);
endinterface

[sv/dpv_sp_cfg.sv]
// ---------------------------------------------------------------------------
// dpv_sp_cfg
// Configuration register file with write port and reset defaults.
// ---------------------------------------------------------------------------
module dpv_sp_cfg
	import dpv_sp_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data,
	output cfg_t                cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_code       <= '0;
			cfg_q.step_code        <= StepW'(2383);
			cfg_q.pulse_code       <= PulseW'(23831);
			cfg_q.vzero_start_code <= VzW'(32);
			cfg_q.vzero_peak_code  <= VzW'(32);
			cfg_q.step_count       <= CountW'(121);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_START_CODE:  cfg_q.start_code       <= cfg_data[StartW-1:0];
				CFG_STEP_CODE:   cfg_q.step_code        <= cfg_data[StepW-1:0];
				CFG_PULSE_CODE:  cfg_q.pulse_code       <= cfg_data[PulseW-1:0];
				CFG_VZERO_START: cfg_q.vzero_start_code <= cfg_data[VzW-1:0];
				CFG_VZERO_PEAK:  cfg_q.vzero_peak_code  <= cfg_data[VzW-1:0];
				CFG_STEP_COUNT:  cfg_q.step_count       <= cfg_data[CountW-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[sv/dpv_sp_vbias.sv]
// ---------------------------------------------------------------------------
// dpv_sp_vbias
// Converts a fixed-point level and vzero code into the VBIAS and VZERO codes.
// ---------------------------------------------------------------------------
module dpv_sp_vbias
	import dpv_sp_pkg::*;
(
	input  logic signed [LevelW-1:0] level,
	input  logic [VzW-1:0]           vzero,
	output logic [VbiasW-1:0]        vbias_code,
	output logic [VzCodeW-1:0]       vzero_code
);

	localparam int unsigned SumW = LevelW + 1;
	localparam int unsigned FlW  = SumW - 1 - FracBits;

	logic signed [SumW-1:0] sum;
	logic [FlW-1:0]         fl;
	logic [FlW-1:0]         vz64;
	logic                   dec;
	logic [FlW-1:0]         val;

	always_comb begin
		// vzero * 64 in fixed point is vzero shifted by 6 + frac bits
		sum  = {level[LevelW-1], level}
			+ $signed(SumW'({vzero, {(6 + FracBits){1'b0}}}));
		fl   = sum[SumW-2:FracBits];
		vz64 = FlW'({vzero, 6'b0});
		dec  = fl < vz64;
		val  = fl - FlW'(dec);
		if (sum[SumW-1] || (dec && fl == '0)) begin
			vbias_code = '0;
		end else if (val > FlW'(VbiasMax)) begin
			vbias_code = VbiasMax;
		end else begin
			vbias_code = val[VbiasW-1:0];
		end
		vzero_code = vzero[VzW-1] ? VzMax : vzero[VzCodeW-1:0];
	end

endmodule

[sv/dpv_staircase_pulse_dac_generator_unit.sv]
// ---------------------------------------------------------------------------
// dpv_staircase_pulse_dac_generator_unit
// Staircase and pulse DAC word generator for differential pulse voltammetry.
// ---------------------------------------------------------------------------
// usage:
//   each item on in asks for one DAC word: pulse_phase 0 builds a baseline
//   word and advances the staircase, pulse_phase 1 adds the pulse height to
//   the last base. each accepted item gives one item on out, unless the sweep
//   has finished, in which case nothing is emitted.
//   registers are written through cfg_we / cfg_index / cfg_data while idle.
// timing:
//   one item per cycle sustained while out is taken. an accepted request is
//   held in the stage register, then in the output register that drives out:
//   the ramp state update and base multiply-add sit before the stage register,
//   the vbias floor and clamp before the output register.
// reset:
//   arst_n puts the ramp into its initialise state, clears position and base,
//   and loads default register values.
// stalls:
//   when out is not taken the output and stage registers hold; in.ready drops
//   only once both are full, so one more item is accepted behind a waiting one.
// ---------------------------------------------------------------------------
module dpv_staircase_pulse_dac_generator_unit
	import dpv_sp_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	dpv_sp_in_if.sink           in,
	dpv_sp_out_if.source        out,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data
);

	localparam int unsigned ProdW = CountW + StepW;

	cfg_t cfg;

	dpv_sp_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// ramp state
	ramp_phase_t              ph_q, ph_mid;
	logic [CountW-1:0]        pos_q, pos_mid, pos_nxt;
	logic signed [BaseW-1:0]  base_q, base_new, base_use;
	logic [VzW-1:0]           vz_q, vz_mid;

	logic [CountW-1:0]        count, half;
	logic                     emit, advance;
	logic [ProdW-1:0]         prod;
	logic signed [LevelW-1:0] base_raw, level;

	// pipeline
	logic                     valid_s1;
	logic signed [LevelW-1:0] level_s1;
	logic [VzW-1:0]           vz_s1;
	logic [CountW-1:0]        step_s1;

	logic                     out_valid_q;
	logic [VbiasW-1:0]        vbias_q;
	logic [VzCodeW-1:0]       vzcode_q;
	logic [CountW-1:0]        step_q;
	logic [VbiasW-1:0]        vbias_c;
	logic [VzCodeW-1:0]       vzcode_c;

	logic out_load_ok, adv_s1, acc;

	assign count = (cfg.step_count > CountW'(MaxSteps)) ? CountW'(MaxSteps) : cfg.step_count;
	assign half  = count >> 1;

	// next ramp phase
	always_comb begin
		ph_mid  = ph_q;
		pos_mid = pos_q;
		vz_mid  = vz_q;
		unique case (ph_q)
			PH_INIT: begin
				ph_mid  = PH_FIRST;
				pos_mid = '0;
				vz_mid  = cfg.vzero_start_code;
			end
			PH_FIRST: begin
				if (pos_q >= half) begin
					ph_mid = PH_SECOND;
					vz_mid = cfg.vzero_peak_code;
				end
			end
			PH_SECOND: begin
				if (pos_q >= count) begin
					ph_mid = PH_STOP;
				end
			end
			default: ;
		endcase
	end

	// ramp outputs: base and level for this item
	always_comb begin
		emit     = ph_mid != PH_STOP;
		advance  = emit && !in.pulse_phase;
		prod     = ProdW'(pos_mid) * ProdW'(cfg.step_code);
		base_raw = $signed({{(LevelW - ProdW){1'b0}}, prod})
			+ $signed({{(LevelW - StartW){cfg.start_code[StartW-1]}}, cfg.start_code});
		// saturate to the base range
		if (base_raw[LevelW-1] != base_raw[LevelW-2]) begin
			base_new = {base_raw[LevelW-1], {(BaseW - 1){~base_raw[LevelW-1]}}};
		end else begin
			base_new = base_raw[BaseW-1:0];
		end
		base_use = advance ? base_new : base_q;
		pos_nxt  = advance ? pos_mid + CountW'(1) : pos_mid;
		level    = {base_use[BaseW-1], base_use};
		if (in.pulse_phase) begin
			level = level
				+ $signed({{(LevelW - PulseW){cfg.pulse_code[PulseW-1]}}, cfg.pulse_code});
		end
	end

	assign out_load_ok = !out_valid_q || out.ready;
	assign adv_s1      = valid_s1 && out_load_ok;
	assign in.ready    = !valid_s1 || out_load_ok;
	assign acc         = in.valid && in.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= PH_INIT;
			pos_q  <= '0;
			base_q <= '0;
			vz_q   <= '0;
		end else if (acc) begin
			ph_q   <= ph_mid;
			pos_q  <= pos_nxt;
			base_q <= base_use;
			vz_q   <= vz_mid;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (acc) begin
			valid_s1 <= emit;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			level_s1 <= level;
			vz_s1    <= vz_mid;
			step_s1  <= pos_nxt;
		end
	end

	dpv_sp_vbias u_vbias (
		.level      (level_s1),
		.vzero      (vz_s1),
		.vbias_code (vbias_c),
		.vzero_code (vzcode_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			vbias_q  <= vbias_c;
			vzcode_q <= vzcode_c;
			step_q   <= step_s1;
		end
	end

	assign out.valid      = out_valid_q;
	assign out.vbias_code = vbias_q;
	assign out.vzero_code = vzcode_q;
	assign out.dac_word   = {vzcode_q, vbias_q};
	assign out.step_index = step_q;

endmodule
